// File: hdl/life_generation_step_macros.svh
// Assertion macros for the life generation step checker.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef LIFE_GENERATION_STEP_MACROS_SVH
`define LIFE_GENERATION_STEP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LGS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgs check failed");

// Next-cycle implication, held off during reset.
`define LGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgs check failed");

`endif

// File: hdl/lgs_pkg.sv
// Shared constants and types for the life generation step block.
// Used by the top level and its checker; no dependencies.
package lgs_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 512;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  // register and field widths
  localparam int CFG_ROWS_W = 9;
  localparam int CFG_COLS_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int ACT_W      = 2;
  localparam int S_TDATA_W  = 24;
  localparam int S_TUSER_W  = ACT_W;
  localparam int M_TDATA_W  = 8;
  localparam int M_TUSER_W  = 1;

  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 9'd200;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 10'd500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_DO,
    ST_ADV_RD_CUR,
    ST_ADV_RD_NXT,
    ST_ADV_LOAD,
    ST_ADV_RUN,
    ST_ADV_WB,
    ST_ADV_NEXT,
    ST_DONE
  } state_t;

endpackage

// File: hdl/lgs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/life_generation_step.sv
// Game of life (B3/S23) grid engine: one row-wide RAM, one cell evaluator.
// Depends on lgs_pkg and lgs_ram.
//
// Usage:
//   s_* channel takes one item: tuser = action, tdata = row, col, cell_in.
//   m_* channel returns exactly one result per item: tdata = cell_out,
//   tuser = status (1 when a write or read falls outside the region).
//   cfg_* channel writes rows_in_use (index 0) or cols_in_use (index 1);
//   cfg_ready is always high, writes are expected while the block is idle.
// Sequencing:
//   Write or read: the row is read, then written back on a write, then the
//   result is loaded into the output register. Advance: row by row in the
//   single neighbor-count unit, with the result loaded after the last row
//   is written back. s_tready is low while an item is in work.
// Reset:
//   rst clears the grid by a pass over the RAM, one row per cycle, over
//   all MAX_ROWS (256) rows, with s_tready low; cfg writes are taken.
// Stalls:
//   A result waits in the output register while m_tready is low; the next
//   item may be accepted meanwhile, but its result waits behind it.
module life_generation_step
  import lgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // row[7:0], col[16:8], cell_in[17], zero pad
  input  logic [S_TUSER_W-1:0]  s_tuser,   // action[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // cell_out[0], zero pad
  output logic [M_TUSER_W-1:0]  m_tuser,   // status[0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  state_t state, state_next;

  logic [CFG_ROWS_W-1:0] rows_in_use;
  logic [CFG_COLS_W-1:0] cols_in_use;
  logic [RCNT_W-1:0]     nr;
  logic [CCNT_W-1:0]     nc;

  // latched item
  logic [ACT_W-1:0] act;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             cin_q;
  logic             in_reg;

  // sweep counters
  logic [ROW_W-1:0]  r;
  logic [CCNT_W-1:0] k;
  logic              last_row;
  logic              nxt_in_region;

  // row buffers of the old generation and the new row being built
  logic [MAX_COLS-1:0] prev_row, cur_row, nxt_row, out_row;
  logic [2:0]          win_l, win_m, win_in;
  logic                m_raw;
  logic [3:0]          cnt;
  logic                rule_bit, new_bit;

  // results
  logic res_cell, res_status;
  logic out_valid, out_cell, out_status;

  // RAM port
  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata, row_mod;

  lgs_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // region clamp
  always_comb begin
    if (int'(rows_in_use) > MAX_ROWS) begin
      nr = RCNT_W'(MAX_ROWS);
    end else begin
      nr = RCNT_W'(rows_in_use);
    end
    if (int'(cols_in_use) > MAX_COLS) begin
      nc = CCNT_W'(MAX_COLS);
    end else begin
      nc = CCNT_W'(cols_in_use);
    end
  end

  assign in_reg = (RCNT_W'(row_q) < nr) && (CCNT_W'(col_q) < nc);
  assign last_row = (RCNT_W'(r) + RCNT_W'(1)) == nr;
  assign nxt_in_region = ((RCNT_W + 1)'(r) + (RCNT_W + 1)'(2)) < (RCNT_W + 1)'(nr);

  // neighbor count and rule; the window holds columns k-2, k-1 and k
  always_comb begin
    if (k < nc) begin
      win_in = {nxt_row[0], cur_row[0], prev_row[0]};
    end else begin
      win_in = 3'b000;
    end
    cnt = 4'(win_l[0]) + 4'(win_l[1]) + 4'(win_l[2]) + 4'(win_m[0]) + 4'(win_m[2])
        + 4'(win_in[0]) + 4'(win_in[1]) + 4'(win_in[2]);
    rule_bit = (cnt == BIRTH_COUNT) || (win_m[1] && (cnt == SURVIVE_COUNT));
    // columns outside the region keep their old value
    new_bit = (k <= nc) ? rule_bit : m_raw;
  end

  always_comb begin
    row_mod        = ram_rdata;
    row_mod[col_q] = cin_q;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (r == ROW_W'(MAX_ROWS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          priority if (s_tuser == ACT_WRITE || s_tuser == ACT_READ) begin
            state_next = ST_ACC_RD;
          end else if (s_tuser == ACT_ADVANCE && nr != '0) begin
            state_next = ST_ADV_RD_CUR;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ACC_RD:     state_next = ST_ACC_DO;
      ST_ACC_DO:     state_next = ST_DONE;
      ST_ADV_RD_CUR: state_next = ST_ADV_RD_NXT;
      ST_ADV_RD_NXT: state_next = ST_ADV_LOAD;
      ST_ADV_LOAD:   state_next = ST_ADV_RUN;
      ST_ADV_RUN: begin
        if (k == CCNT_W'(MAX_COLS)) state_next = ST_ADV_WB;
      end
      ST_ADV_WB:     state_next = last_row ? ST_DONE : ST_ADV_NEXT;
      ST_ADV_NEXT:   state_next = ST_ADV_RUN;
      ST_DONE: begin
        if (!out_valid || m_tready) state_next = ST_IDLE;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = r;
    ram_wdata = out_row;
    ram_raddr = r;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_IDLE:       s_tready = 1'b1;
      ST_ACC_RD:     ram_raddr = row_q;
      ST_ACC_DO: begin
        ram_we    = (act == ACT_WRITE) && in_reg;
        ram_waddr = row_q;
        ram_wdata = row_mod;
      end
      ST_ADV_RD_CUR: ram_raddr = '0;
      ST_ADV_RD_NXT: ram_raddr = ROW_W'(1);
      ST_ADV_WB: begin
        ram_we    = 1'b1;
        ram_raddr = r + ROW_W'(2);
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = M_TDATA_W'(out_cell);
  assign m_tuser   = M_TUSER_W'(out_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      r           <= '0;
      k           <= '0;
      out_valid   <= 1'b0;
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ROWS: rows_in_use <= cfg_data[CFG_ROWS_W-1:0];
          REG_COLS: cols_in_use <= cfg_data[CFG_COLS_W-1:0];
          default: begin
          end
        endcase
      end

      // in ST_DONE the output register is reloaded below instead
      if (out_valid && m_tready && state != ST_DONE) out_valid <= 1'b0;

      unique case (state)
        ST_CLEAR: r <= r + ROW_W'(1);
        ST_IDLE: begin
          if (s_tvalid) begin
            act        <= s_tuser;
            row_q      <= s_tdata[ROW_W-1:0];
            col_q      <= s_tdata[ROW_W+COL_W-1:ROW_W];
            cin_q      <= s_tdata[ROW_W+COL_W];
            res_cell   <= 1'b0;
            res_status <= 1'b0;
            r          <= '0;
          end
        end
        ST_ACC_DO: begin
          res_cell   <= (act == ACT_READ) && in_reg && ram_rdata[col_q];
          res_status <= !in_reg;
        end
        ST_ADV_RD_NXT: begin
          cur_row  <= ram_rdata;
          prev_row <= '0;
        end
        ST_ADV_LOAD: begin
          nxt_row <= (nr > RCNT_W'(1)) ? ram_rdata : '0;
          k       <= '0;
          win_l   <= '0;
          win_m   <= '0;
        end
        ST_ADV_RUN: begin
          if (k < CCNT_W'(MAX_COLS)) begin
            prev_row <= {prev_row[0], prev_row[MAX_COLS-1:1]};
            cur_row  <= {cur_row[0], cur_row[MAX_COLS-1:1]};
            nxt_row  <= {nxt_row[0], nxt_row[MAX_COLS-1:1]};
            m_raw    <= cur_row[0];
          end
          win_l <= win_m;
          win_m <= win_in;
          if (k != '0) out_row <= {new_bit, out_row[MAX_COLS-1:1]};
          k <= k + CCNT_W'(1);
        end
        ST_ADV_WB: begin
          // row buffers are back in place after a full rotation
          prev_row <= cur_row;
          cur_row  <= nxt_row;
        end
        ST_ADV_NEXT: begin
          nxt_row <= nxt_in_region ? ram_rdata : '0;
          r       <= r + ROW_W'(1);
          k       <= '0;
          win_l   <= '0;
          win_m   <= '0;
        end
        ST_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid  <= 1'b1;
            out_cell   <= res_cell;
            out_status <= res_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/lgs_checker.sv
// Port-level checks for life_generation_step, bound to the top level.
// Depends on life_generation_step_macros.svh and lgs_pkg.
`include "life_generation_step_macros.svh"

module lgs_checker
  import lgs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // a stalled result holds
  `LGS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // a flagged item never returns a live cell
  `LGS_ASSERT_IMPL(a_flag_no_cell, m_tvalid && m_tuser[0], m_tdata[0] == 1'b0)

  // the block is not ready in the cycle after it takes an item
  `LGS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind life_generation_step lgs_checker u_lgs_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for life_generation_step (B3/S23 game of life grid engine).
// Keeps its own copy of the grid and region registers and checks every result in order.
// Depends on lgs_pkg and the life_generation_step RTL.
`timescale 1ns / 1ps

module tb;
  import lgs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic alive;
    logic flagged;
  } cell_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // row[7:0], col[16:8], cell_in[17], zero pad
  logic [S_TUSER_W-1:0]  s_tuser;   // action[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // cell_out[0], zero pad
  logic [M_TUSER_W-1:0]  m_tuser;   // status[0]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // grid shadow and region registers
  bit           life_grid [MAX_ROWS][MAX_COLS];
  bit           life_next [MAX_ROWS][MAX_COLS];
  int unsigned  rows_reg;
  int unsigned  cols_reg;
  cell_result_t result_q[$];

  bit           no_idle;
  int unsigned  sink_hold;
  int unsigned  items_sent;
  int unsigned  advances_sent;
  int unsigned  results_checked;
  int unsigned  region_changes;
  int unsigned  error_count;

  life_generation_step dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int eff_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  // One generation over the region; anything outside it counts as dead and is left alone.
  function automatic void step_generation();
    int nr, nc, r, c, dr, dc, live_n;
    nr = eff_rows();
    nc = eff_cols();
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        live_n = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
                r + dr < nr && c + dc < nc)
              live_n += life_grid[r + dr][c + dc];
          end
        end
        life_next[r][c] = life_grid[r][c] ? (live_n == 2 || live_n == 3) : (live_n == 3);
      end
    end
    for (r = 0; r < nr; r++)
      for (c = 0; c < nc; c++)
        life_grid[r][c] = life_next[r][c];
  endfunction

  function automatic cell_result_t predict_result(input logic [ACT_W-1:0] action,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic cell_in);
    cell_result_t res;
    res = '{alive: 1'b0, flagged: 1'b0};
    case (action)
      ACT_WRITE, ACT_READ: begin
        if (row < eff_rows() && col < eff_cols()) begin
          if (action == ACT_WRITE)
            life_grid[row][col] = cell_in;
          else
            res.alive = life_grid[row][col];
        end else begin
          res.flagged = 1'b1;
        end
      end
      ACT_ADVANCE: step_generation();
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] action, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic cell_in);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {{(S_TDATA_W - ROW_W - COL_W - 1){1'b0}}, cell_in, col, row};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    result_q.push_back(predict_result(action, row, col, cell_in));
    items_sent++;
    if (action == ACT_ADVANCE)
      advances_sent++;
  endtask

  task automatic send_noise_item();
    send_item(ACT_W'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 255)),
              COL_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Writes both region registers back to back; only called with the block idle.
  task automatic set_region(input logic [CFG_DATA_W-1:0] rows,
                            input logic [CFG_DATA_W-1:0] cols);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    rows_reg = 32'(rows[CFG_ROWS_W-1:0]);
    cfg_index <= REG_COLS;
    cfg_data  <= cols;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cols_reg = 32'(cols[CFG_COLS_W-1:0]);
    cfg_valid <= 1'b0;
    region_changes++;
  endtask

  task automatic test_reset_state();
    send_item(ACT_READ, 8'd0, 9'd0, 1'b0);        // all dead after reset
    send_item(ACT_READ, 8'd199, 9'd499, 1'b0);
    send_item(ACT_WRITE, 8'd199, 9'd499, 1'b1);   // far corner of the reset region
    send_item(ACT_READ, 8'd199, 9'd499, 1'b0);
    send_item(ACT_WRITE, 8'd200, 9'd0, 1'b1);     // one row past
    send_item(ACT_READ, 8'd0, 9'd500, 1'b1);      // one column past
    send_item(ACT_UNUSED, 8'd255, 9'd511, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_grid();
    set_region(10'h1FF, 10'h3FF);                 // both clamp to the whole grid
    send_item(ACT_WRITE, 8'd254, 9'd510, 1'b1);   // still-life block in the far corner
    send_item(ACT_WRITE, 8'd254, 9'd511, 1'b1);
    send_item(ACT_WRITE, 8'd255, 9'd510, 1'b1);
    send_item(ACT_WRITE, 8'd255, 9'd511, 1'b1);
    send_item(ACT_WRITE, 8'd0, 9'd0, 1'b1);       // blinker along the top edge
    send_item(ACT_WRITE, 8'd0, 9'd1, 1'b1);
    send_item(ACT_WRITE, 8'd0, 9'd2, 1'b1);
    send_item(ACT_ADVANCE, 8'd0, 9'd0, 1'b0);
    send_item(ACT_READ, 8'd0, 9'd0, 1'b0);        // death
    send_item(ACT_READ, 8'd1, 9'd1, 1'b0);        // birth
    send_item(ACT_READ, 8'd0, 9'd1, 1'b0);        // survival
    send_item(ACT_READ, 8'd255, 9'd511, 1'b0);
    wait_drained();
  endtask

  task automatic test_empty_region();
    set_region(10'h200, 10'd512);                 // row count masks down to zero
    send_item(ACT_WRITE, 8'd0, 9'd0, 1'b1);
    send_item(ACT_READ, 8'd0, 9'd1, 1'b0);
    send_item(ACT_ADVANCE, 8'd255, 9'd511, 1'b1);
    wait_drained();
    set_region(10'd3, 10'd0);
    send_item(ACT_READ, 8'd1, 9'd1, 1'b0);
    wait_drained();
  endtask

  task automatic test_cells_outside_kept();
    set_region(10'd1, 10'd1);
    send_item(ACT_WRITE, 8'd0, 9'd0, 1'b1);
    send_item(ACT_ADVANCE, 8'd0, 9'd0, 1'b0);     // live neighbors sit outside: lone cell dies
    send_item(ACT_READ, 8'd0, 9'd0, 1'b0);
    wait_drained();
    set_region(10'd4, 10'd4);
    send_item(ACT_READ, 8'd1, 9'd1, 1'b0);
    send_item(ACT_READ, 8'd0, 9'd1, 1'b0);
    wait_drained();
  endtask

  // Seed a small patch, run a few generations, probe it; a few stray items mixed in.
  task automatic test_random_regions();
    int unsigned n_rows, n_cols, win_c;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      no_idle = (phase == 3);
      n_rows = $urandom_range(3, 10);
      case ($urandom_range(0, 3))
        0, 1:    n_cols = $urandom_range(3, 20);
        2:       n_cols = MAX_COLS;
        default: n_cols = $urandom_range(1, 1023);
      endcase
      set_region(CFG_DATA_W'(n_rows), CFG_DATA_W'(n_cols));
      win_c = (n_cols < 16) ? n_cols : 16;
      repeat (8)
        send_item(ACT_WRITE, ROW_W'($urandom_range(0, n_rows - 1)),
                  COL_W'($urandom_range(0, win_c - 1)), $urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        send_item(ACT_ADVANCE, ROW_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 511)),
                  1'($urandom_range(0, 1)));
        repeat (3)
          send_item(ACT_READ, ROW_W'($urandom_range(0, n_rows - 1)),
                    COL_W'($urandom_range(0, win_c - 1)), 1'($urandom_range(0, 1)));
      end
      repeat (2) send_noise_item();
      if ($urandom_range(0, 1) != 0)
        wait_drained();
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Result side holds off long enough for the block to back up into its input.
  task automatic test_output_stall();
    set_region(10'd6, 10'd12);
    no_idle = 1'b1;
    sink_hold = 150;
    repeat (10)
      send_item($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, ROW_W'($urandom_range(0, 5)),
                COL_W'($urandom_range(0, 11)), 1'($urandom_range(0, 1)));
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned gap;
    @(posedge clk iff !rst);
    forever begin
      if (sink_hold != 0) begin
        m_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("result with nothing expected: cell_out %0d status %0d", m_tdata[0], m_tuser[0]);
        error_count++;
      end else begin
        want = result_q.pop_front();
        if (m_tdata[0] !== want.alive) begin
          $error("cell_out mismatch: expected %0d, got %0d", want.alive, m_tdata[0]);
          error_count++;
        end
        if (m_tuser[0] !== want.flagged) begin
          $error("status mismatch: expected %0d, got %0d", want.flagged, m_tuser[0]);
          error_count++;
        end
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    #(25_000_000);
    $error("timed out with %0d results outstanding", result_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    sink_hold = 0;
    rows_reg  = 32'(ROWS_RESET);
    cols_reg  = 32'(COLS_RESET);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_full_grid();
    test_empty_region();
    test_cells_outside_kept();
    test_random_regions();
    test_output_stall();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d advances) across %0d region settings; checked %0d results.",
             items_sent, advances_sent, region_changes, results_checked);
    $display("Mismatches and unexpected results: %0d", error_count);
    if (error_count == 0 && result_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
